// ----- hdl/gbn_pkg.sv -----
package gbn_pkg;

	// register indexes
	localparam logic [0:0] REG_IOU_THRESHOLD = 1'd0;
	localparam logic [0:0] REG_SIZE_BIAS     = 1'd1;

	localparam int COORD_W = 16;
	localparam int SIDE_W  = 17;
	localparam int AREA_W  = 34;
	localparam int THR_W   = 17;
	localparam int NUM_W   = 16;
	localparam int CORN_W  = 64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AREA,
		ST_READ,
		ST_CMP,
		ST_DONE,
		ST_OUT
	} gbn_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture accepted box
		logic calc_area;  // register own area
		logic rd_en;      // issue store read
		logic cmp_en;     // run overlap test on read data
		logic wr_en;      // store kept box
	} gbn_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;        // valid overlap test said suppress
		logic cmp_busy;   // pipeline still holds compares
	} gbn_stat_t;

	// side length hi - lo, plus 16 when bias is set, clamped at zero
	function automatic logic [SIDE_W-1:0] side_len(input logic [COORD_W-1:0] lo,
		input logic [COORD_W-1:0] hi, input logic bias);
		logic [SIDE_W:0] d;
		begin
			d = {2'b00, hi} - {2'b00, lo} + {{(SIDE_W-4){1'b0}}, bias, 4'b0000};
			side_len = d[SIDE_W] ? '0 : d[SIDE_W-1:0];
		end
	endfunction

endpackage

// ----- hdl/gbn_ram.sv -----
module gbn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

// ----- hdl/gbn_datapath.sv -----
module gbn_datapath import gbn_pkg::*; #(
	parameter int MAX_KEPT = 256,
	parameter int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gbn_cmd_t            cmd,
	input  logic [AW-1:0]       rd_addr,
	input  logic [AW-1:0]       wr_addr,
	input  logic [COORD_W-1:0]  in_x1,
	input  logic [COORD_W-1:0]  in_y1,
	input  logic [COORD_W-1:0]  in_x2,
	input  logic [COORD_W-1:0]  in_y2,
	input  logic [THR_W-1:0]    thr,
	input  logic                bias,
	output gbn_stat_t           stat
);
	localparam int RAM_D = 1 << AW;

	logic [COORD_W-1:0] x1_q, y1_q, x2_q, y2_q;
	logic [SIDE_W-1:0]  bw_q, bh_q;
	logic [AREA_W-1:0]  area_q;
	logic [CORN_W-1:0]  corn_rd;
	logic [AREA_W-1:0]  area_rd;
	logic               rd_v_s1, v_s2, v_s3, v_s4;
	logic [SIDE_W-1:0]  w_s2, h_s2;
	logic [AREA_W-1:0]  ka_s2;
	logic [AREA_W-1:0]  inter_s3;
	logic [AREA_W:0]    sum_s3;
	logic [AREA_W:0]    uni_s4;
	logic [AREA_W-1:0]  inter_s4;
	logic [AREA_W+16:0] lhs_s5, rhs_s5;
	logic               nz_s5, v_s5;
	logic [COORD_W-1:0] kx1, ky1, kx2, ky2;

	// box capture and own side lengths
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x1_q <= in_x1;
			y1_q <= in_y1;
			x2_q <= in_x2;
			y2_q <= in_y2;
		end
		if (cmd.load) begin
			bw_q <= side_len(in_x1, in_x2, bias);
			bh_q <= side_len(in_y1, in_y2, bias);
		end
		if (cmd.calc_area) begin
			area_q <= bw_q * bh_q;
		end
	end

	gbn_ram #(.WIDTH(CORN_W), .DEPTH(RAM_D)) u_corn (
		.clk(clk), .wr_en(cmd.wr_en), .wr_addr(wr_addr),
		.wr_data({y2_q, x2_q, y1_q, x1_q}),
		.rd_en(cmd.rd_en), .rd_addr(rd_addr), .rd_data(corn_rd)
	);

	gbn_ram #(.WIDTH(AREA_W), .DEPTH(RAM_D)) u_area (
		.clk(clk), .wr_en(cmd.wr_en), .wr_addr(wr_addr), .wr_data(area_q),
		.rd_en(cmd.rd_en), .rd_addr(rd_addr), .rd_data(area_rd)
	);

	assign kx1 = corn_rd[15:0];
	assign ky1 = corn_rd[31:16];
	assign kx2 = corn_rd[47:32];
	assign ky2 = corn_rd[63:48];

	// valid pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.rd_en;
			v_s2 <= rd_v_s1 && cmd.cmp_en;
			v_s3 <= v_s2 && cmd.cmp_en;
			v_s4 <= v_s3 && cmd.cmp_en;
			v_s5 <= v_s4 && cmd.cmp_en;
		end
	end

	// overlap sides, intersection, union, cross products
	always_ff @(posedge clk) begin
		w_s2 <= side_len((x1_q > kx1) ? x1_q : kx1, (x2_q < kx2) ? x2_q : kx2, bias);
		h_s2 <= side_len((y1_q > ky1) ? y1_q : ky1, (y2_q < ky2) ? y2_q : ky2, bias);
		ka_s2 <= area_rd;
		inter_s3 <= w_s2 * h_s2;
		sum_s3 <= {1'b0, area_q} + {1'b0, ka_s2};
		inter_s4 <= inter_s3;
		uni_s4 <= (sum_s3 > {1'b0, inter_s3}) ? sum_s3 - {1'b0, inter_s3} : '0;
		lhs_s5 <= {1'b0, inter_s4, 16'h0000};
		rhs_s5 <= 51'(uni_s4) * 51'(thr);
		nz_s5 <= (uni_s4 != '0);
	end

	assign stat.hit = v_s5 && nz_s5 && (lhs_s5 >= rhs_s5);
	assign stat.cmp_busy = rd_v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
endmodule

// ----- hdl/gbn_ctrl.sv -----
module gbn_ctrl import gbn_pkg::*; #(
	parameter int MAX_KEPT = 256,
	parameter int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1,
	parameter int CW = $clog2(MAX_KEPT + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  logic          in_sos,
	input  logic          out_ready,
	input  gbn_stat_t     stat,
	output logic          in_ready,
	output logic          out_valid,
	output logic          res_kept,
	output logic          res_ovf,
	output logic [NUM_W-1:0] res_num,
	output gbn_cmd_t      cmd,
	output logic [AW-1:0] rd_addr,
	output logic [AW-1:0] wr_addr
);
	gbn_state_t state_q, state_d;
	logic [CW-1:0]    count_q, idx_q;
	logic [NUM_W-1:0] pos_q;
	logic             hit_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_fire) state_d = ST_AREA;
			ST_AREA: state_d = (count_q == '0) ? ST_DONE : ST_READ;
			ST_READ: begin
				if (stat.hit) state_d = ST_CMP;
				else if (idx_q + 1'b1 == count_q) state_d = ST_CMP;
			end
			ST_CMP: if (!stat.cmp_busy) state_d = ST_DONE;
			ST_DONE: state_d = ST_OUT;
			ST_OUT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_fire;
			end
			ST_AREA: cmd.calc_area = 1'b1;
			ST_READ: begin
				cmd.rd_en = !stat.hit;
				cmd.cmp_en = !stat.hit;
			end
			ST_CMP: cmd.cmp_en = !stat.hit;
			ST_DONE: cmd.wr_en = !hit_q && !stat.hit && (count_q < CW'(MAX_KEPT));
			ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

	assign rd_addr = idx_q[AW-1:0];
	assign wr_addr = count_q[AW-1:0];
	assign res_kept = !hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pos_q <= '0;
			idx_q <= '0;
			hit_q <= 1'b0;
			res_num <= '0;
			res_ovf <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_fire) begin
				idx_q <= '0;
				hit_q <= 1'b0;
				res_num <= in_sos ? '0 : pos_q;
				pos_q <= in_sos ? NUM_W'(1) : pos_q + 1'b1;
				if (in_sos) count_q <= '0;
			end
			if (state_q == ST_READ && !stat.hit) idx_q <= idx_q + 1'b1;
			if (stat.hit) hit_q <= 1'b1;
			if (state_q == ST_DONE) begin
				res_ovf <= 1'b0;
				if (!hit_q && !stat.hit) begin
					if (count_q < CW'(MAX_KEPT)) count_q <= count_q + 1'b1;
					else res_ovf <= 1'b1;
				end
			end
		end
	end

	// store fill never exceeds its depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_KEPT)) else $error("kept count beyond depth");
	// a store write only for a kept box
	a_wr_kept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |=> !res_ovf && res_kept) else $error("write for a suppressed box");
	// overflow only reported with kept
	a_ovf_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_ovf |-> res_kept) else $error("overflow on suppressed box");
endmodule

// ----- hdl/greedy_box_nms_unit.sv -----
// Greedy box suppression: boxes arrive in descending score order, one result per box.
// With a non-empty store a box is compared with each stored kept box in turn (one RAM read
// a cycle), then the compare pipeline drains before the result is offered; an empty store
// skips the scan and the drain; a suppressing hit ends the scan early. Only one box is in
// flight.
// Set start_of_set on the first box of a set to empty the store; the store needs no
// clearing after reset. A kept box that finds the store full is reported with overflow.
module greedy_box_nms_unit import gbn_pkg::*; #(
	parameter int MAX_KEPT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // left_edge, top_edge, right_edge, bottom_edge
	input  logic        s_tuser,  // start_of_set
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // kept, box_number, store_overflow, zero fill
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

	logic [THR_W-1:0] thr_q;
	logic             bias_q;
	gbn_cmd_t         cmd;
	gbn_stat_t        stat;
	logic [AW-1:0]    rd_addr, wr_addr;
	logic             kept, ovf;
	logic [NUM_W-1:0] num;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 17'd32768;
			bias_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IOU_THRESHOLD: thr_q <= cfg_data[THR_W-1:0];
				REG_SIZE_BIAS: bias_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	gbn_ctrl #(.MAX_KEPT(MAX_KEPT)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(s_tvalid && s_tready), .in_sos(s_tuser),
		.out_ready(m_tready), .stat(stat), .in_ready(s_tready), .out_valid(m_tvalid),
		.res_kept(kept), .res_ovf(ovf), .res_num(num), .cmd(cmd),
		.rd_addr(rd_addr), .wr_addr(wr_addr)
	);

	gbn_datapath #(.MAX_KEPT(MAX_KEPT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .rd_addr(rd_addr), .wr_addr(wr_addr),
		.in_x1(s_tdata[15:0]), .in_y1(s_tdata[31:16]), .in_x2(s_tdata[47:32]),
		.in_y2(s_tdata[63:48]), .thr(thr_q), .bias(bias_q), .stat(stat)
	);

	assign m_tdata = {6'b0, ovf, num, kept};
endmodule

// ----- tb/greedy_box_nms_unit_checker.sv -----
module greedy_box_nms_unit_checker import gbn_pkg::*; #(
	parameter int MAX_KEPT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          verdicts_seen,
	output int          kept_seen,
	output int          overflow_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic              store_overflow;
		logic [NUM_W-1:0]  box_number;
		logic              kept;
	} verdict_t;

	// predictor state
	logic [CORN_W-1:0] kept_box [MAX_KEPT];
	logic [AREA_W-1:0] kept_area [MAX_KEPT];
	int unsigned       kept_total;
	logic [NUM_W-1:0]  position;
	logic [THR_W-1:0]  threshold;
	logic              bias_on;
	verdict_t          verdict_queue [$];

	function automatic logic [SIDE_W-1:0] span(input logic [15:0] lo, input logic [15:0] hi,
		input logic bias);
		longint d;
		begin
			d = longint'(hi) - longint'(lo) + (bias ? 16 : 0);
			span = (d > 0) ? d[SIDE_W-1:0] : '0;
		end
	endfunction

	// work out the verdict for one box and update the kept store
	function automatic verdict_t suppress_box(input logic first, input logic [63:0] box);
		logic [15:0] x1, y1, x2, y2, kx1, ky1, kx2, ky2;
		logic [63:0] area, inter, total, uni;
		logic [127:0] lhs, rhs;
		logic keep;
		verdict_t v;
		begin
			x1 = box[15:0]; y1 = box[31:16]; x2 = box[47:32]; y2 = box[63:48];
			if (first) begin
				kept_total = 0;
				position = 0;
			end
			v.box_number = position;
			position = position + 1'b1;
			area = 64'(span(x1, x2, bias_on)) * 64'(span(y1, y2, bias_on));
			keep = 1'b1;
			for (int k = 0; k < kept_total && keep; k++) begin
				{ky2, kx2, ky1, kx1} = kept_box[k];
				inter = 64'(span(x1 > kx1 ? x1 : kx1, x2 < kx2 ? x2 : kx2, bias_on)) *
					64'(span(y1 > ky1 ? y1 : ky1, y2 < ky2 ? y2 : ky2, bias_on));
				total = area + 64'(kept_area[k]);
				uni = total > inter ? total - inter : 64'd0;
				lhs = 128'(inter) << 16;
				rhs = 128'(threshold) * 128'(uni);
				if (uni != 0 && lhs >= rhs) keep = 1'b0;
			end
			v.kept = keep;
			v.store_overflow = 1'b0;
			if (keep) begin
				if (kept_total < MAX_KEPT) begin
					kept_box[kept_total] = box;
					kept_area[kept_total] = area[AREA_W-1:0];
					kept_total++;
				end else begin
					v.store_overflow = 1'b1;
				end
			end
			suppress_box = v;
		end
	endfunction

	assign pending = verdict_queue.size();

	// watch the three channels
	always @(posedge clk or negedge arst_n) begin
		verdict_t want, got;
		if (!arst_n) begin
			verdict_queue.delete();
			kept_total = 0;
			position = 0;
			threshold = 17'd32768;
			bias_on = 1'b1;
			fail_count <= 0;
			verdicts_seen <= 0;
			kept_seen <= 0;
			overflow_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_IOU_THRESHOLD) threshold = cfg_data[THR_W-1:0];
				else if (cfg_index == REG_SIZE_BIAS) bias_on = cfg_data[0];
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[17:0];
				verdicts_seen <= verdicts_seen + 1;
				if (got.kept) kept_seen <= kept_seen + 1;
				if (got.store_overflow) overflow_seen <= overflow_seen + 1;
				if (verdict_queue.size() == 0) begin
					if (fail_count < 10)
						$display("mismatch: unexpected verdict %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = verdict_queue.pop_front();
					if (got !== want || m_tdata[23:18] !== '0) begin
						if (fail_count < 10)
							$display("mismatch: kept %b/%b number %0d/%0d overflow %b/%b",
								want.kept, got.kept, want.box_number, got.box_number,
								want.store_overflow, got.store_overflow);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				verdict_queue.insert(verdict_queue.size(), suppress_box(s_tuser, s_tdata));
		end
	end
endmodule

// ----- tb/greedy_box_nms_unit_test.sv -----
module greedy_box_nms_unit_test import gbn_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_KEPT = 256;
	localparam int CYCLE_LIMIT = 3_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = REG_IOU_THRESHOLD;
	logic [31:0] cfg_data = '0;

	int fail_count, pending, verdicts_seen, kept_seen, overflow_seen;
	int cycles = 0;
	int boxes_sent = 0;
	bit hold_off = 1'b0;

	always #5 clk = ~clk;

	greedy_box_nms_unit #(.MAX_KEPT(MAX_KEPT)) DUT (.*);
	greedy_box_nms_unit_checker #(.MAX_KEPT(MAX_KEPT)) checker_i (.*);

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("greedy_box_nms_unit regression: fail");
			$finish;
		end
	end

	// receiver: own stall pattern, plus a long hold-off when asked
	always @(posedge clk) begin
		if (hold_off) m_tready <= 1'b0;
		else case ($urandom_range(0, 3))
			0: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= 1'b1;
		endcase
	end

	// one box transaction, with a random gap before bursts
	task automatic send_box(input logic first, input logic [15:0] x1, input logic [15:0] y1,
		input logic [15:0] x2, input logic [15:0] y2);
		begin
			if ($urandom_range(0, 5) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tuser <= first;
			s_tdata <= {y2, x2, y1, x1};
			do @(posedge clk); while (!s_tready);
			boxes_sent++;
		end
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
		begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while (pending != 0) @(posedge clk);
			repeat (MAX_KEPT + 20) @(posedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= value;
			do @(posedge clk); while (!cfg_ready);
			cfg_valid <= 1'b0;
		end
	endtask

	// random box near a cluster centre, so overlaps are common
	task automatic send_random(input logic first, input int cx, input int cy);
		int w, h, x1, y1;
		begin
			w = $urandom_range(0, 300);
			h = $urandom_range(0, 300);
			x1 = cx + $urandom_range(0, 160);
			y1 = cy + $urandom_range(0, 160);
			if ($urandom_range(0, 15) == 0)
				send_box(first, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			else
				send_box(first, 16'(x1), 16'(y1), 16'((x1 + w > 65535) ? 65535 : x1 + w),
					16'((y1 + h > 65535) ? 65535 : y1 + h));
		end
	endtask

	initial begin
		int thr [6] = '{0, 32768, 65536, 65537, 131071, 19661};
		int cx, cy;
		int n;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, identical box, inverted box, zero union
		send_box(1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
		send_box(1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_box(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_box(1'b0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
		send_box(1'b0, 16'd100, 16'd100, 16'd200, 16'd200);
		send_box(1'b0, 16'd500, 16'd500, 16'd10, 16'd10);
		send_box(1'b1, 16'd100, 16'd100, 16'd200, 16'd200);
		send_box(1'b0, 16'd110, 16'd100, 16'd210, 16'd200);
		send_box(1'b0, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
		write_reg(REG_SIZE_BIAS, 32'd0);
		send_box(1'b1, 16'd5, 16'd5, 16'd5, 16'd5);
		send_box(1'b0, 16'd5, 16'd5, 16'd5, 16'd5);
		send_box(1'b0, 16'd0, 16'd0, 16'd40, 16'd40);
		send_box(1'b0, 16'd0, 16'd0, 16'd40, 16'd40);
		send_box(1'b0, 16'd80, 16'd0, 16'd20, 16'd40);

		// fill the store past its depth with disjoint boxes, receiver held off first
		write_reg(REG_IOU_THRESHOLD, 32'd65536);
		fork
			begin
				hold_off = 1'b1;
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end
		join_none
		for (int i = 0; i < MAX_KEPT + 4; i++)
			send_box(i == 0, 16'(i * 200), 16'(i * 64), 16'(i * 200 + 50), 16'(i * 64 + 30));

		// random phases over threshold and bias settings
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_IOU_THRESHOLD, thr[ph] | ($urandom & 32'hFFFE_0000));
			write_reg(REG_SIZE_BIAS, ph % 2);
			for (int s = 0; s < 8; s++) begin
				cx = $urandom_range(0, 65000);
				cy = $urandom_range(0, 65000);
				n = $urandom_range(3, 14);
				for (int b = 0; b < n; b++)
					send_random(b == 0, cx, cy);
			end
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (MAX_KEPT + 40) @(posedge clk);
		$display("covered %0d boxes, %0d verdicts, %0d kept, %0d store overflows",
			boxes_sent, verdicts_seen, kept_seen, overflow_seen);
		$display("six threshold settings incl. 0, 1.0 and above, both size bias values");
		if (fail_count == 0 && pending == 0)
			$display("greedy_box_nms_unit regression: pass");
		else
			$display("greedy_box_nms_unit regression: fail");
		$finish;
	end
endmodule

// ----- greedy_box_nms_unit.f -----
hdl/gbn_pkg.sv
hdl/gbn_ram.sv
hdl/gbn_datapath.sv
hdl/gbn_ctrl.sv
hdl/greedy_box_nms_unit.sv
tb/greedy_box_nms_unit_checker.sv
tb/greedy_box_nms_unit_test.sv
